// File: hdl/slcd_pkg.sv
package slcd_pkg;

    localparam int MAX_FRAME = 256;
    localparam int CNT_W     = $clog2(MAX_FRAME + 1);

    localparam logic [CNT_W-1:0] LEN_POS        = CNT_W'(2);
    localparam logic [CNT_W-1:0] FRAME_OVERHEAD = CNT_W'(4);
    localparam logic [CNT_W-1:0] MAX_COUNT      = CNT_W'(MAX_FRAME);

    localparam logic [7:0] SYNC_RESET = 8'h55;

    // register word indexes
    localparam logic REG_SYNC = 1'b0;

    // per-byte event codes
    localparam logic [2:0] EV_SKIP = 3'd0;
    localparam logic [2:0] EV_IN   = 3'd1;
    localparam logic [2:0] EV_GOOD = 3'd2;
    localparam logic [2:0] EV_BAD  = 3'd3;
    localparam logic [2:0] EV_OVF  = 3'd4;

    typedef struct packed {
        logic [7:0] byte_index;
        logic [7:0] data_out;
    } result_data_t;

endpackage

// File: hdl/sync_length_checksum_deframer.sv
// an accepted word goes to the output register, or to the skid stage if the output stalls
// throughput: one word per cycle while s_tready high; framing: one add and compare per word
// an output register plus a one-word skid stage decouple s_tready from m_tready
// reset (rst_n low, asynchronous): hunting, length and sum cleared, sync_value back to 0x55
// the output and skid stages come out of reset empty
module sync_length_checksum_deframer
    import slcd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] rx_byte
    // output stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [15:0]  m_tdata,   // [7:0] data_out, [15:8] byte_index
    output logic [2:0]   m_tuser    // [2:0] event_res
);

    logic [7:0]       sync_reg;
    logic [CNT_W-1:0] taken_reg, taken_next;
    logic [7:0]       len_reg, len_next;
    logic [7:0]       sum_reg, sum_next;

    logic             out_valid_reg, skid_valid_reg;
    result_data_t     out_data_reg, skid_data_reg;
    logic [2:0]       out_ev_reg, skid_ev_reg;

    result_data_t     res_data;
    logic [2:0]       res_ev;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] frame_len;
    logic [7:0]       len_eff;
    logic             in_accept;
    logic             out_take;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SYNC) ? {24'd0, sync_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg <= SYNC_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_SYNC))
        begin
            sync_reg <= pwdata[7:0];
        end
    end

    // per-byte framing logic
    assign in_accept = s_tvalid && s_tready;
    assign out_take  = out_valid_reg && m_tready;
    assign s_tready  = !skid_valid_reg;

    assign count     = taken_reg + CNT_W'(1);
    // the length byte is in effect for its own end check
    assign len_eff   = (taken_reg == LEN_POS) ? s_tdata : len_reg;
    assign frame_len = CNT_W'(len_eff) + FRAME_OVERHEAD;

    always_comb
    begin
        taken_next          = taken_reg;
        len_next            = len_reg;
        sum_next            = sum_reg;
        res_ev              = EV_SKIP;
        res_data.data_out   = s_tdata;
        res_data.byte_index = 8'd0;
        if (taken_reg == '0 && s_tdata != sync_reg)
        begin
            res_ev = EV_SKIP;
        end
        else if (taken_reg < MAX_COUNT)
        begin
            res_data.byte_index = taken_reg[7:0];
            len_next            = len_eff;
            if (count >= FRAME_OVERHEAD && count >= frame_len)
            begin
                res_ev     = (s_tdata == sum_reg) ? EV_GOOD : EV_BAD;
                taken_next = '0;
                len_next   = 8'd0;
                sum_next   = 8'd0;
            end
            else
            begin
                res_ev     = EV_IN;
                sum_next   = sum_reg + s_tdata;
                taken_next = count;
            end
        end
        else
        begin
            res_ev     = EV_OVF;
            taken_next = '0;
            len_next   = 8'd0;
            sum_next   = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taken_reg <= '0;
            len_reg   <= 8'd0;
            sum_reg   <= 8'd0;
        end
        else if (in_accept)
        begin
            taken_reg <= taken_next;
            len_reg   <= len_next;
            sum_reg   <= sum_next;
        end
    end

    // output register with skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (skid_valid_reg)
            begin
                if (out_take)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (in_accept)
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_data_reg <= skid_data_reg;
                out_ev_reg   <= skid_ev_reg;
            end
        end
        else if (in_accept)
        begin
            if (!out_valid_reg || m_tready)
            begin
                out_data_reg <= res_data;
                out_ev_reg   <= res_ev;
            end
            else
            begin
                skid_data_reg <= res_data;
                skid_ev_reg   <= res_ev;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_ev_reg;

    // assertions
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds a word while output stage is empty");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        taken_reg <= MAX_COUNT)
        else $error("byte count beyond frame limit");

    a_hunt_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (taken_reg == '0) |-> (len_reg == 8'd0 && sum_reg == 8'd0))
        else $error("length or sum left over while hunting");

    a_len_after_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (len_reg != 8'd0) |-> (taken_reg > LEN_POS))
        else $error("length held before length byte was taken");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |=> (out_valid_reg && $stable(out_ev_reg)))
        else $error("stalled result changed");

endmodule

// File: tb/sv/testbench.sv
module testbench;

    import slcd_pkg::*;

    localparam int  CYCLE_LIMIT   = 1000000;
    localparam int  LONG_HOLD     = 300;
    localparam int  DRAIN_CYCLES  = 6;
    localparam int  PHASE_WORDS   = 350;
    localparam logic [2:0] SYNC_ADDR = {REG_SYNC, 2'b00};

    typedef struct packed {
        logic [7:0] data_out;
        logic [7:0] byte_index;
        logic [2:0] event_res;
    } byte_event_t;

    typedef struct packed {
        logic [7:0] rx;
        logic       typed;
        logic [7:0] idx;
        logic [2:0] ev;
    } directed_row_t;

    logic         clk      = 1'b0;
    logic         rst_n    = 1'b0;
    logic         psel     = 1'b0;
    logic         penable  = 1'b0;
    logic         pwrite   = 1'b0;
    logic [2:0]   paddr    = '0;
    logic [31:0]  pwdata   = '0;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata  = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [15:0]  m_tdata;
    logic [2:0]   m_tuser;

    // deframer state as the checker sees it
    logic [7:0]   cfg_sync    = SYNC_RESET;
    logic [8:0]   frame_count = '0;
    logic [7:0]   frame_len   = '0;
    logic [7:0]   frame_sum   = '0;

    byte_event_t  expected_events [$];
    int           framed_words = 0;
    int           fail_cnt     = 0;
    int           cycle_cnt    = 0;
    bit           burst_mode   = 1'b0;
    bit           rx_steady    = 1'b0;
    int           holds_asked  = 0;
    int           holds_served = 0;
    int           stall_left   = 0;
    int           rx_pick;

    // sync value, sync inside a frame, zero length, bad checksum, multi-byte payload
    directed_row_t dir_rows [0:23] = '{
        '{8'h00, 1'b1, 8'd0, EV_SKIP},
        '{8'hFF, 1'b1, 8'd0, EV_SKIP},
        '{8'h55, 1'b1, 8'd0, EV_IN},
        '{8'h55, 1'b1, 8'd1, EV_IN},
        '{8'h00, 1'b1, 8'd2, EV_IN},
        '{8'hAA, 1'b1, 8'd3, EV_GOOD},
        '{8'h55, 1'b0, 8'd0, EV_SKIP},
        '{8'h01, 1'b0, 8'd0, EV_SKIP},
        '{8'h00, 1'b0, 8'd0, EV_SKIP},
        '{8'h00, 1'b1, 8'd3, EV_BAD},
        '{8'h55, 1'b0, 8'd0, EV_SKIP},
        '{8'h00, 1'b0, 8'd0, EV_SKIP},
        '{8'h02, 1'b0, 8'd0, EV_SKIP},
        '{8'hFF, 1'b0, 8'd0, EV_SKIP},
        '{8'h80, 1'b0, 8'd0, EV_SKIP},
        '{8'hD6, 1'b1, 8'd5, EV_GOOD},
        '{8'h54, 1'b1, 8'd0, EV_SKIP},
        '{8'h55, 1'b0, 8'd0, EV_SKIP},
        '{8'h7F, 1'b0, 8'd0, EV_SKIP},
        '{8'h03, 1'b0, 8'd0, EV_SKIP},
        '{8'h00, 1'b0, 8'd0, EV_SKIP},
        '{8'h55, 1'b0, 8'd0, EV_SKIP},
        '{8'hFF, 1'b0, 8'd0, EV_SKIP},
        '{8'h2B, 1'b0, 8'd0, EV_SKIP}
    };

    sync_length_checksum_deframer u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [7:0] rx_byte
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [7:0] data_out, [15:8] byte_index
        .m_tuser  (m_tuser)    // [2:0] event_res
    );

    always #5 clk = ~clk;

    function automatic byte_event_t deframe_step(input logic [7:0] b);
        byte_event_t r;
        logic [8:0]  next_count;
        r.data_out   = b;
        r.byte_index = 8'd0;
        if (frame_count == 9'd0 && b != cfg_sync) begin
            r.event_res = EV_SKIP;
        end
        else if (frame_count < MAX_COUNT) begin
            r.byte_index = frame_count[7:0];
            next_count   = frame_count + 9'd1;
            if (frame_count == LEN_POS)
                frame_len = b;
            if (next_count >= FRAME_OVERHEAD
                && int'(next_count) >= int'(frame_len) + int'(FRAME_OVERHEAD)) begin
                r.event_res = (b == frame_sum) ? EV_GOOD : EV_BAD;
                frame_count = '0;
                frame_len   = '0;
                frame_sum   = '0;
            end
            else begin
                r.event_res = EV_IN;
                frame_sum   = frame_sum + b;
                frame_count = next_count;
            end
        end
        else begin
            // word arrived with a full frame already held
            r.event_res = EV_OVF;
            frame_count = '0;
            frame_len   = '0;
            frame_sum   = '0;
        end
        return r;
    endfunction

    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode || r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic typed = 1'b0,
                             input logic [7:0] t_idx = 8'd0,
                             input logic [2:0] t_ev = EV_SKIP);
        int          gap;
        byte_event_t want;
        gap = sender_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        want = deframe_step(b);
        if (typed)
        begin
            want.byte_index = t_idx;
            want.event_res  = t_ev;
        end
        if (want.event_res != EV_SKIP)
            framed_words++;
        expected_events.push_back(want);
    endtask

    // sends one frame from hunting; cut >= 0 stops after that many bytes
    task automatic send_frame(input int len, input bit bad_sum, input int cut);
        logic [7:0] sum;
        logic [7:0] b;
        int         sent;
        while (frame_count != 9'd0)
            push_byte(8'($urandom_range(0, 255)));
        sum  = cfg_sync;
        sent = 1;
        push_byte(cfg_sync);
        b = 8'($urandom_range(0, 255));
        sum += b;
        if (cut >= 0 && sent >= cut)
            return;
        push_byte(b);
        sent++;
        sum += 8'(len);
        if (cut >= 0 && sent >= cut)
            return;
        push_byte(8'(len));
        sent++;
        for (int i = 0; i < len; i++)
        begin
            if (cut >= 0 && sent >= cut)
                return;
            b = 8'($urandom_range(0, 255));
            sum += b;
            push_byte(b);
            sent++;
        end
        if (bad_sum)
            sum ^= 8'($urandom_range(1, 255));
        push_byte(sum);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_events.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_sync(input logic [7:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= SYNC_ADDR;
        pwdata  <= {24'($urandom()), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_sync = value;
    endtask

    // receiver: random stalls, plus one long hold on request
    always @(posedge clk)
    begin
        if (holds_served != holds_asked)
        begin
            holds_served = holds_asked;
            stall_left   = LONG_HOLD;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (rx_steady)
        begin
            m_tready <= 1'b1;
        end
        else
        begin
            rx_pick = $urandom_range(0, 99);
            if (rx_pick < 70)
            begin
                m_tready <= 1'b1;
            end
            else
            begin
                m_tready <= 1'b0;
                stall_left = (rx_pick < 95) ? $urandom_range(0, 2) : $urandom_range(9, 35);
            end
        end
    end

    always @(posedge clk)
    begin
        byte_event_t  want;
        result_data_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (expected_events.size() == 0)
            begin
                $error("unexpected word: data_out %0h byte_index %0d event_res %0d",
                       got.data_out, got.byte_index, m_tuser);
                fail_cnt++;
            end
            else
            begin
                want = expected_events.pop_front();
                if (got.data_out !== want.data_out)
                begin
                    $error("data_out: expected %0h, got %0h", want.data_out, got.data_out);
                    fail_cnt++;
                end
                if (got.byte_index !== want.byte_index)
                begin
                    $error("byte_index: expected %0d, got %0d",
                           want.byte_index, got.byte_index);
                    fail_cnt++;
                end
                if (m_tuser !== want.event_res)
                begin
                    $error("event_res: expected %0d, got %0d", want.event_res, m_tuser);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("sync_length_checksum_deframer test failed");
            $finish;
        end
    end

    initial
    begin
        logic [7:0] sync_plan [0:3];
        int         pick;
        int         len;
        sync_plan = '{8'h00, 8'hFF, 8'($urandom_range(0, 255)), SYNC_RESET};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            push_byte(dir_rows[i].rx, dir_rows[i].typed, dir_rows[i].idx, dir_rows[i].ev);

        for (int phase = 0; phase < 4; phase++)
        begin
            settle();
            write_sync(sync_plan[phase]);
            @(posedge clk);
            rx_steady  = (phase == 3);
            burst_mode = (phase == 3);
            if (phase == 0)
            begin
                // longest good frame, then one that runs past the frame limit
                send_frame(252, 1'b0, -1);
                send_frame(253, 1'b0, -1);
            end
            if (phase == 1)
            begin
                // hold the output while the sender keeps pushing
                burst_mode = 1'b1;
                holds_asked++;
                send_frame(40, 1'b0, -1);
                burst_mode = 1'b0;
            end
            while (framed_words < PHASE_WORDS * (phase + 1) + 24)
            begin
                if (phase != 3)
                    burst_mode = ($urandom_range(0, 7) == 0);
                pick = $urandom_range(0, 99);
                if (pick < 60)
                begin
                    len = $urandom_range(0, 99);
                    if (len < 85)
                        len = $urandom_range(0, 12);
                    else if (len < 97)
                        len = $urandom_range(13, 60);
                    else if (len < 99)
                        len = $urandom_range(200, 252);
                    else
                        len = $urandom_range(253, 255);
                    send_frame(len, 1'b0, -1);
                end
                else if (pick < 75)
                begin
                    send_frame($urandom_range(0, 12), 1'b1, -1);
                end
                else if (pick < 87)
                begin
                    send_frame($urandom_range(0, 12), 1'b0, $urandom_range(1, 8));
                end
                else
                begin
                    repeat ($urandom_range(1, 6))
                        push_byte(8'($urandom_range(0, 255)));
                end
            end
        end

        settle();
        if (fail_cnt == 0)
            $display("sync_length_checksum_deframer test passed");
        else
            $display("sync_length_checksum_deframer test failed");
        $finish;
    end

endmodule
